// File: rtl/wmc_pkg.sv
// Shared codes and item types of the weighted Markov chain table.
package wmc_pkg;

    localparam int LABEL_W = 16;

    // Operation codes of an input item.
    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_STEP    = 3'd1;
    localparam logic [2:0] OP_JUMP    = 3'd2;
    localparam logic [2:0] OP_DEFAULT = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NEXT  = 2'd1;
    localparam logic [1:0] KIND_DEAD  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_STATE = 2'd1;
    localparam logic [1:0] ERR_FULL     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] state_value;
        logic signed [15:0] successor_value;
        logic [15:0]        weight;
        logic [31:0]        draw;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] next_value;
        logic [1:0]         error;
    } rsp_item_t;

endpackage

// File: rtl/wmc_if.sv
// Valid/ready channel interfaces for the request and response items.
interface wmc_req_if import wmc_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wmc_rsp_if import wmc_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/wmc_seq.sv
// Sequencer that runs each operation over the entry and successor memories.
module wmc_seq import wmc_pkg::*; #(
    parameter int MAX_STATES     = 16,
    parameter int MAX_SUCCESSORS = 16,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wmc_req_if.sink   req,
    output logic      res_valid,
    input  logic      res_ready,
    output rsp_item_t res
);

    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int SCNT_W     = $clog2(MAX_STATES + 1);
    localparam int CNT_W      = $clog2(MAX_SUCCESSORS + 1);
    localparam int SLOT_W     = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
    localparam int TOTAL_W    = WEIGHT_BITS + CNT_W;
    localparam int WIN_W      = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int ENT_W      = LABEL_W + TOTAL_W + CNT_W;
    localparam int SUCC_W     = IDX_W + WEIGHT_BITS;
    localparam int SADDR_W    = IDX_W + SLOT_W;
    localparam int SUCC_DEPTH = 1 << SADDR_W;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [TOTAL_W-1:0] total;
        logic [CNT_W-1:0]   count;
    } ent_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]       target;
        logic [WEIGHT_BITS-1:0] weight;
    } succ_word_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_ENT_RD, S_ENT_USE, S_SRCH_RD, S_SRCH_CMP,
        S_ADD, S_ADD2, S_MUL1, S_MUL2, S_WALK_RD, S_WALK_CMP, S_LBL_RD,
        S_LBL_USE, S_DONE
    } state_t;

    state_t                 state_reg;
    req_item_t              item_reg;
    rsp_item_t              res_reg;
    logic [MAX_STATES-1:0]  used_reg;
    logic [IDX_W-1:0]       cur_idx_reg;
    logic                   cur_valid_reg;
    logic [IDX_W-1:0]       fb_idx_reg;
    logic                   fb_valid_reg;
    logic [SCNT_W-1:0]      scan_cnt_reg;
    logic                   cmp_valid_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   p_found_reg;
    logic [IDX_W-1:0]       p_idx_reg;
    logic                   s_found_reg;
    logic [IDX_W-1:0]       s_idx_reg;
    logic                   f1_found_reg;
    logic [IDX_W-1:0]       f1_idx_reg;
    logic                   f2_found_reg;
    logic [IDX_W-1:0]       f2_idx_reg;
    logic [IDX_W-1:0]       ent_addr_reg;
    logic [TOTAL_W-1:0]     ent_total_reg;
    logic [CNT_W-1:0]       ent_cnt_reg;
    logic [SADDR_W-1:0]     succ_addr_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [63:0]            p_lo_reg;
    logic [63:0]            p_hi_reg;
    logic [TOTAL_W-1:0]     rnd_reg;
    logic [IDX_W-1:0]       ns_idx_reg;

    // Memory ports.
    logic                   ent_we;
    logic [IDX_W-1:0]       ent_waddr;
    logic [ENT_W-1:0]       ent_wdata;
    logic [IDX_W-1:0]       ent_raddr;
    logic [ENT_W-1:0]       ent_rdata;
    logic                   succ_we;
    logic [SADDR_W-1:0]     succ_waddr;
    logic [SUCC_W-1:0]      succ_wdata;
    logic [SUCC_W-1:0]      succ_rdata;

    ent_word_t              ent_rd;
    succ_word_t             succ_rd;
    logic [LABEL_W-1:0]     src_lbl;
    logic [LABEL_W-1:0]     dst_lbl;
    logic [WEIGHT_BITS-1:0] w_in;
    logic [IDX_W-1:0]       add_np;
    logic [IDX_W-1:0]       add_ns;
    logic                   add_ok;
    logic                   add_new_ns;
    logic                   lbl_self;
    logic                   srch_hit;
    logic                   walk_hit;
    logic [CNT_W-1:0]       k_inc;
    logic [CNT_W-1:0]       k_dec;
    logic [CNT_W-1:0]       k_dec2;
    logic [CNT_W-1:0]       cnt_dec;
    logic [63:0]            tot_ext;

    function automatic rsp_item_t mk_res(input logic [1:0] k, input logic [15:0] v,
                                         input logic [1:0] e);
        rsp_item_t r;
        r.kind       = k;
        r.next_value = v;
        r.error      = e;
        return r;
    endfunction

    wmc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_STATES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    wmc_ram #(.WIDTH(SUCC_W), .DEPTH(SUCC_DEPTH)) u_succ_ram (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (succ_wdata),
        .raddr (succ_addr_reg),
        .rdata (succ_rdata)
    );

    // Decoded views and helper values.
    always_comb
    begin
        ent_rd     = ent_word_t'(ent_rdata);
        succ_rd    = succ_word_t'(succ_rdata);
        src_lbl    = item_reg.state_value;
        dst_lbl    = item_reg.successor_value;
        w_in       = WEIGHT_BITS'(item_reg.weight[WIN_W-1:0]);
        lbl_self   = (src_lbl == dst_lbl);
        srch_hit   = (succ_rd.target == s_idx_reg);
        walk_hit   = (rnd_reg < TOTAL_W'(succ_rd.weight));
        k_inc      = k_reg + CNT_W'(1);
        k_dec      = k_reg - CNT_W'(1);
        k_dec2     = k_reg - CNT_W'(2);
        cnt_dec    = ent_cnt_reg - CNT_W'(1);
        tot_ext    = 64'(ent_total_reg);
    end

    // Placement of a new transition: source entry and successor entry.
    always_comb
    begin
        add_np     = p_found_reg ? p_idx_reg : f1_idx_reg;
        add_new_ns = !s_found_reg && !lbl_self;
        if (s_found_reg)
        begin
            add_ns = s_idx_reg;
        end
        else if (lbl_self)
        begin
            add_ns = add_np;
        end
        else
        begin
            add_ns = p_found_reg ? f1_idx_reg : f2_idx_reg;
        end
        add_ok = (p_found_reg || f1_found_reg)
              && (s_found_reg || lbl_self || (p_found_reg ? f1_found_reg : f2_found_reg))
              && !(p_found_reg && (ent_cnt_reg >= CNT_W'(MAX_SUCCESSORS)));
    end

    // Memory addressing and writes.
    always_comb
    begin
        ent_raddr  = (state_reg == S_SCAN) ? scan_cnt_reg[IDX_W-1:0] : ent_addr_reg;
        ent_we     = 1'b0;
        ent_waddr  = add_np;
        ent_wdata  = {src_lbl, ent_total_reg + TOTAL_W'(w_in), ent_cnt_reg + CNT_W'(1)};
        succ_we    = 1'b0;
        succ_waddr = {add_np, ent_cnt_reg[SLOT_W-1:0]};
        succ_wdata = {add_ns, w_in};
        case (state_reg)
            S_SRCH_CMP:
            begin
                if (srch_hit)
                begin
                    ent_we     = 1'b1;
                    ent_waddr  = p_idx_reg;
                    ent_wdata  = {src_lbl,
                                  ent_total_reg - TOTAL_W'(succ_rd.weight) + TOTAL_W'(w_in),
                                  ent_cnt_reg};
                    succ_we    = 1'b1;
                    succ_waddr = succ_addr_reg;
                    succ_wdata = {s_idx_reg, w_in};
                end
            end
            S_ADD:
            begin
                ent_we  = add_ok;
                succ_we = add_ok;
            end
            S_ADD2:
            begin
                ent_we    = 1'b1;
                ent_waddr = ns_idx_reg;
                ent_wdata = {dst_lbl, TOTAL_W'(0), CNT_W'(0)};
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Operation sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            res_reg       <= '0;
            used_reg      <= '0;
            cur_idx_reg   <= '0;
            cur_valid_reg <= 1'b0;
            fb_idx_reg    <= '0;
            fb_valid_reg  <= 1'b0;
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            p_found_reg   <= 1'b0;
            p_idx_reg     <= '0;
            s_found_reg   <= 1'b0;
            s_idx_reg     <= '0;
            f1_found_reg  <= 1'b0;
            f1_idx_reg    <= '0;
            f2_found_reg  <= 1'b0;
            f2_idx_reg    <= '0;
            ent_addr_reg  <= '0;
            ent_total_reg <= '0;
            ent_cnt_reg   <= '0;
            succ_addr_reg <= '0;
            k_reg         <= '0;
            p_lo_reg      <= '0;
            p_hi_reg      <= '0;
            rnd_reg       <= '0;
            ns_idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        item_reg <= req.data;
                        case (req.data.op) inside
                            OP_SET, OP_JUMP, OP_DEFAULT:
                            begin
                                scan_cnt_reg  <= '0;
                                cmp_valid_reg <= 1'b0;
                                p_found_reg   <= 1'b0;
                                s_found_reg   <= 1'b0;
                                f1_found_reg  <= 1'b0;
                                f2_found_reg  <= 1'b0;
                                state_reg     <= S_SCAN;
                            end
                            OP_STEP:
                            begin
                                if (cur_valid_reg)
                                begin
                                    ent_addr_reg <= cur_idx_reg;
                                    state_reg    <= S_ENT_RD;
                                end
                                else
                                begin
                                    res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_CLEAR:
                            begin
                                used_reg      <= '0;
                                cur_idx_reg   <= '0;
                                cur_valid_reg <= 1'b0;
                                fb_idx_reg    <= '0;
                                fb_valid_reg  <= 1'b0;
                                res_reg       <= mk_res(KIND_NONE, '0, ERR_NONE);
                                state_reg     <= S_DONE;
                            end
                            default:
                            begin
                                res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                // One entry read per cycle; the compare acts on each entry in the cycle after its read.
                S_SCAN:
                begin
                    if (scan_cnt_reg < SCNT_W'(MAX_STATES))
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
                        scan_cnt_reg  <= scan_cnt_reg + SCNT_W'(1);
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                    if (cmp_valid_reg)
                    begin
                        if (used_reg[cmp_idx_reg])
                        begin
                            if (!p_found_reg && ent_rd.label == src_lbl)
                            begin
                                p_found_reg <= 1'b1;
                                p_idx_reg   <= cmp_idx_reg;
                            end
                            if (!s_found_reg && ent_rd.label == dst_lbl)
                            begin
                                s_found_reg <= 1'b1;
                                s_idx_reg   <= cmp_idx_reg;
                            end
                        end
                        else if (!f1_found_reg)
                        begin
                            f1_found_reg <= 1'b1;
                            f1_idx_reg   <= cmp_idx_reg;
                        end
                        else if (!f2_found_reg)
                        begin
                            f2_found_reg <= 1'b1;
                            f2_idx_reg   <= cmp_idx_reg;
                        end
                    end
                    else if (scan_cnt_reg == SCNT_W'(MAX_STATES))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    case (item_reg.op)
                        OP_SET:
                        begin
                            if (p_found_reg)
                            begin
                                ent_addr_reg <= p_idx_reg;
                                state_reg    <= S_ENT_RD;
                            end
                            else
                            begin
                                ent_total_reg <= '0;
                                ent_cnt_reg   <= '0;
                                state_reg     <= S_ADD;
                            end
                        end
                        OP_JUMP:
                        begin
                            if (p_found_reg)
                            begin
                                cur_idx_reg   <= p_idx_reg;
                                cur_valid_reg <= 1'b1;
                                res_reg       <= mk_res(KIND_NONE, '0, ERR_NONE);
                            end
                            else
                            begin
                                res_reg <= mk_res(KIND_ERROR, '0, ERR_NO_STATE);
                            end
                            state_reg <= S_DONE;
                        end
                        OP_DEFAULT:
                        begin
                            if (!p_found_reg)
                            begin
                                res_reg   <= mk_res(KIND_ERROR, '0, ERR_NO_STATE);
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                fb_idx_reg   <= p_idx_reg;
                                fb_valid_reg <= 1'b1;
                                if (!cur_valid_reg)
                                begin
                                    cur_idx_reg   <= p_idx_reg;
                                    cur_valid_reg <= 1'b1;
                                    res_reg       <= mk_res(KIND_NONE, '0, ERR_NONE);
                                    state_reg     <= S_DONE;
                                end
                                else
                                begin
                                    ent_addr_reg <= cur_idx_reg;
                                    state_reg    <= S_ENT_RD;
                                end
                            end
                        end
                        default:
                        begin
                            res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_ENT_RD:
                begin
                    state_reg <= S_ENT_USE;
                end

                // Entry word is on the read port: act on its count and total.
                S_ENT_USE:
                begin
                    ent_total_reg <= ent_rd.total;
                    ent_cnt_reg   <= ent_rd.count;
                    case (item_reg.op)
                        OP_SET:
                        begin
                            if (s_found_reg && ent_rd.count != '0)
                            begin
                                k_reg         <= '0;
                                succ_addr_reg <= {p_idx_reg, SLOT_W'(0)};
                                state_reg     <= S_SRCH_RD;
                            end
                            else
                            begin
                                state_reg <= S_ADD;
                            end
                        end
                        OP_DEFAULT:
                        begin
                            if (ent_rd.count == '0)
                            begin
                                cur_idx_reg <= p_idx_reg;
                            end
                            res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                            state_reg <= S_DONE;
                        end
                        OP_STEP:
                        begin
                            if (ent_rd.count == '0)
                            begin
                                if (fb_valid_reg)
                                begin
                                    cur_idx_reg <= fb_idx_reg;
                                end
                                res_reg   <= mk_res(KIND_DEAD, '0, ERR_NONE);
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_MUL1;
                            end
                        end
                        default:
                        begin
                            res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_SRCH_RD:
                begin
                    state_reg <= S_SRCH_CMP;
                end

                // A hit replaces the weight in place; else search on or append.
                S_SRCH_CMP:
                begin
                    if (srch_hit)
                    begin
                        res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                        state_reg <= S_DONE;
                    end
                    else if (k_inc == ent_cnt_reg)
                    begin
                        state_reg <= S_ADD;
                    end
                    else
                    begin
                        k_reg         <= k_inc;
                        succ_addr_reg <= {p_idx_reg, k_inc[SLOT_W-1:0]};
                        state_reg     <= S_SRCH_RD;
                    end
                end

                // Append the successor, or report full; the writes happen in this cycle.
                S_ADD:
                begin
                    if (!add_ok)
                    begin
                        res_reg   <= mk_res(KIND_ERROR, '0, ERR_FULL);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        used_reg[add_np] <= 1'b1;
                        if (!cur_valid_reg)
                        begin
                            cur_idx_reg   <= add_np;
                            cur_valid_reg <= 1'b1;
                        end
                        if (add_new_ns)
                        begin
                            ns_idx_reg <= add_ns;
                            state_reg  <= S_ADD2;
                        end
                        else
                        begin
                            res_reg   <= mk_res(KIND_NONE, '0, ERR_NONE);
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_ADD2:
                begin
                    used_reg[ns_idx_reg] <= 1'b1;
                    res_reg              <= mk_res(KIND_NONE, '0, ERR_NONE);
                    state_reg            <= S_DONE;
                end

                // Scale the draw to the total over two registered products.
                S_MUL1:
                begin
                    p_lo_reg  <= item_reg.draw * tot_ext[31:0];
                    p_hi_reg  <= item_reg.draw * tot_ext[63:32];
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    rnd_reg       <= TOTAL_W'(p_lo_reg[63:32]) + TOTAL_W'(p_hi_reg);
                    k_reg         <= ent_cnt_reg;
                    succ_addr_reg <= {cur_idx_reg, cnt_dec[SLOT_W-1:0]};
                    state_reg     <= S_WALK_RD;
                end

                S_WALK_RD:
                begin
                    state_reg <= S_WALK_CMP;
                end

                // Walk the successors newest first, subtracting weights.
                S_WALK_CMP:
                begin
                    if (walk_hit)
                    begin
                        cur_idx_reg  <= succ_rd.target;
                        ent_addr_reg <= succ_rd.target;
                        state_reg    <= S_LBL_RD;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg - TOTAL_W'(succ_rd.weight);
                        if (k_reg == CNT_W'(1))
                        begin
                            res_reg   <= mk_res(KIND_ERROR, '0, ERR_OVERFLOW);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg         <= k_dec;
                            succ_addr_reg <= {cur_idx_reg, k_dec2[SLOT_W-1:0]};
                            state_reg     <= S_WALK_RD;
                        end
                    end
                end

                S_LBL_RD:
                begin
                    state_reg <= S_LBL_USE;
                end

                S_LBL_USE:
                begin
                    res_reg   <= mk_res(KIND_NEXT, ent_rd.label, ERR_NONE);
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/weighted_markov_chain_table_core.sv
// Top level of the weighted Markov chain table: sequencer plus output register.
//
//  Channel  Direction  Payload                                         Accept
//  req      in         op, state_value, successor_value, weight, draw  valid & ready
//  rsp      out        kind, next_value, error                         valid & ready
//
// One item is worked at a time; the block takes a new item as soon as the
// sequencer is idle, even while the previous result still waits in rsp.
// Set weight: a label scan of the entry memory, one entry per cycle, then a search of the
// successors for the pair. Jump and set default: the same label scan, then for set default
// a read of the current entry. Step: an entry read, a scaled draw, then a successor walk.
// Clear and unused codes go straight to the result. Reset is asynchronous and empties the table at once.
// A stalled rsp holds the finished item; the sequencer waits until it can hand over.
module weighted_markov_chain_table_core import wmc_pkg::*; #(
    parameter int MAX_STATES     = 16,
    parameter int MAX_SUCCESSORS = 16,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wmc_req_if.sink   req,
    wmc_rsp_if.source rsp
);

    logic      res_valid;
    logic      res_ready;
    rsp_item_t res;
    logic      out_valid_reg;
    rsp_item_t out_item_reg;

    wmc_seq #(
        .MAX_STATES     (MAX_STATES),
        .MAX_SUCCESSORS (MAX_SUCCESSORS),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register separating the sequencer from the response channel.
    assign res_ready = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // An error code appears only with an error result.
    a_err_only_with_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.kind != KIND_ERROR |-> rsp.data.error == ERR_NONE)
        else $error("error code set on a result that is not an error");

    // A label appears only with an emitted next state.
    a_label_only_with_next: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.kind != KIND_NEXT |-> rsp.data.next_value == '0)
        else $error("label set on a result without a next state");

    // A finished item waiting on the output register stays unchanged.
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("sequencer result changed while waiting for hand-over");

endmodule
